### sv/rrfg_pkg.sv
package rrfg_pkg;

    localparam int MAX_PIXELS = 64;
    localparam int MIN_PIXELS = 4;

    localparam int PIX_W      = 6;   // pixel index and rotation offset
    localparam int LEN_W      = 7;   // strip length register
    localparam int BSH_W      = 3;   // brightness shift register
    localparam int SEC_W      = 5;   // section length and ramp numerators
    localparam int DIVIDEND_W = 13;  // 0xff times a section position
    localparam int Q_W        = 8;   // ramp quotient
    localparam int DIV_STEPS  = 8;   // one quotient bit per step

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_SHIFT = 1'b1;

    localparam logic [LEN_W-1:0] STRIP_LENGTH_RESET = 7'd64;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

endpackage

### sv/rrfg_ramp_div.sv
module rrfg_ramp_div (
    input  logic                            aclk,
    input  rrfg_pkg::div_ctrl_t             ctrl,
    input  logic [rrfg_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [rrfg_pkg::SEC_W-1:0]      divisor,
    output logic [rrfg_pkg::Q_W-1:0]        quotient
);
    import rrfg_pkg::*;

    // restoring divider, one quotient bit per step; the upper dividend bits
    // are already below the divisor since the quotient fits in Q_W bits
    logic [SEC_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   sh_reg, sh_next;
    logic [SEC_W:0]   trial;
    logic [SEC_W:0]   diff;
    logic             ge;

    always_comb begin
        trial    = {rem_reg, sh_reg[Q_W-1]};
        ge       = (trial >= {1'b0, divisor});
        diff     = trial - {1'b0, divisor};
        rem_next = rem_reg;
        sh_next  = sh_reg;
        if (ctrl.load) begin
            rem_next = dividend[DIVIDEND_W-1:Q_W];
            sh_next  = dividend[Q_W-1:0];
        end else if (ctrl.step) begin
            rem_next = ge ? diff[SEC_W-1:0] : trial[SEC_W-1:0];
            sh_next  = {sh_reg[Q_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign quotient = sh_reg;

endmodule

### sv/rainbow_ring_frame_generator_top.sv
// channel  | dir | handshake             | payload
// ---------+-----+-----------------------+------------------------------------------
// s_       | in  | s_tvalid / s_tready   | s_tdata[0] frame_tick
// m_       | out | m_tvalid / m_tready   | m_tdata pixel, rgb; m_tlast last pixel
// cfg_     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a tick request is taken in idle, then offset + 1 is reduced modulo the
// length by repeated subtraction, then each pixel runs setup, 8 divide steps,
// emit; the three colour channels share those steps, each with its own
// bit-serial divider. requests are taken only between frames. a stalled
// m_tready holds the emit step of each pixel.
// aresetn is synchronous: offset 0, strip length 64, brightness shift 0.
module rainbow_ring_frame_generator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [0] frame_tick
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,    // [5:0] pixel_index, [13:6] red,
                                                        // [20:14] green, [28:21] blue
    output logic                            m_tlast,    // last_pixel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rrfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrfg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rrfg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SETUP,
        S_DIV,
        S_EMIT
    } state_t;

    // (x * 43) >> 7 equals x / 3 for x below 128
    localparam logic [11:0] DIV3_MUL = 12'd43;
    localparam int          DIV3_SHR = 7;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  strip_length_reg, strip_length_next;
    logic [BSH_W-1:0]  brightness_shift_reg, brightness_shift_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [SEC_W-1:0]  len_reg, len_next;
    logic [BSH_W-1:0]  bsh_reg, bsh_next;
    logic [PIX_W-1:0]  offset_reg, offset_next;
    logic [LEN_W-1:0]  mod_reg, mod_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic [PIX_W-1:0]  d_reg, d_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;

    logic [LEN_W-1:0]      n_clamped;
    logic [11:0]           len_prod;
    logic [LEN_W-1:0]      d7, l7, len2, len3, j7, i7;
    logic [SEC_W-1:0]      num_r, num_g, num_b;
    logic [DIVIDEND_W-1:0] dvd_r, dvd_g, dvd_b;
    logic [Q_W-1:0]        q_r, q_g, q_b;
    logic [7:0]            r_out, b_out;
    logic [6:0]            g_out;
    logic                  out_load;
    logic                  last_pix;
    logic [PIX_W-1:0]      d_inc;
    div_ctrl_t             dctl;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    always_comb begin
        if (strip_length_reg < LEN_W'(MIN_PIXELS)) begin
            n_clamped = LEN_W'(MIN_PIXELS);
        end else if (strip_length_reg > LEN_W'(MAX_PIXELS)) begin
            n_clamped = LEN_W'(MAX_PIXELS);
        end else begin
            n_clamped = strip_length_reg;
        end
    end

    assign len_prod = (12'(n_reg) + 12'd2) * DIV3_MUL;

    // ramp numerators for the current pixel distance
    always_comb begin
        d7    = {1'b0, d_reg};
        l7    = {2'b00, len_reg};
        len2  = l7 << 1;
        len3  = len2 + l7;
        j7    = d7 + n_reg - len2;
        i7    = '0;
        num_r = '0;
        num_g = '0;
        num_b = '0;
        if (d7 < l7) begin
            num_r = SEC_W'(l7 - d7);
            num_g = SEC_W'(d7);
            // wrap overlap: red and blue from the third ramp
            if (j7 < l7) begin
                num_r = SEC_W'(j7);
                num_b = SEC_W'(l7 - j7);
            end
        end else if (d7 < len2) begin
            i7    = d7 - l7;
            num_g = SEC_W'(l7 - i7);
            num_b = SEC_W'(i7);
        end else if (d7 < len3) begin
            i7    = d7 - len2;
            num_b = SEC_W'(l7 - i7);
            num_r = SEC_W'(i7);
        end
        dvd_r = {num_r, 8'b0} - DIVIDEND_W'(num_r);
        dvd_g = {1'b0, num_g, 7'b0} - DIVIDEND_W'(num_g);
        dvd_b = {num_b, 8'b0} - DIVIDEND_W'(num_b);
    end

    assign dctl.load = (state_reg == S_SETUP);
    assign dctl.step = (state_reg == S_DIV);

    rrfg_ramp_div u_div_r (
        .aclk     (aclk),
        .ctrl     (dctl),
        .dividend (dvd_r),
        .divisor  (len_reg),
        .quotient (q_r)
    );

    rrfg_ramp_div u_div_g (
        .aclk     (aclk),
        .ctrl     (dctl),
        .dividend (dvd_g),
        .divisor  (len_reg),
        .quotient (q_g)
    );

    rrfg_ramp_div u_div_b (
        .aclk     (aclk),
        .ctrl     (dctl),
        .dividend (dvd_b),
        .divisor  (len_reg),
        .quotient (q_b)
    );

    assign r_out    = q_r >> bsh_reg;
    assign g_out    = q_g[6:0] >> bsh_reg;
    assign b_out    = q_b >> bsh_reg;
    assign out_load = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);
    assign last_pix = ({1'b0, pix_reg} + 7'd1 == n_reg);
    assign d_inc    = ({1'b0, d_reg} + 7'd1 == n_reg) ? '0 : d_reg + 1'b1;

    always_comb begin
        state_next            = state_reg;
        strip_length_next     = strip_length_reg;
        brightness_shift_next = brightness_shift_reg;
        n_next                = n_reg;
        len_next              = len_reg;
        bsh_next              = bsh_reg;
        offset_next           = offset_reg;
        mod_next              = mod_reg;
        pix_next              = pix_reg;
        d_next                = d_reg;
        cnt_next              = cnt_reg;
        m_tvalid_next         = m_tvalid_reg;
        m_tdata_next          = m_tdata_reg;
        m_tlast_next          = m_tlast_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_STRIP_LENGTH:     strip_length_next = cfg_data[LEN_W-1:0];
                REG_BRIGHTNESS_SHIFT: brightness_shift_next = cfg_data[BSH_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tdata[0]) begin
                    n_next     = n_clamped;
                    bsh_next   = brightness_shift_reg;
                    mod_next   = {1'b0, offset_reg} + 7'd1;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                len_next = len_prod[DIV3_SHR +: SEC_W];
                // reduce offset + 1 modulo the length by repeated subtraction
                if (mod_reg >= n_reg) begin
                    mod_next = mod_reg - n_reg;
                end else begin
                    offset_next = mod_reg[PIX_W-1:0];
                    d_next      = (mod_reg == '0) ? '0 : PIX_W'(n_reg - mod_reg);
                    pix_next    = '0;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP: begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'(DIV_STEPS - 1)) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, b_out, g_out, r_out, pix_reg};
                    m_tlast_next  = last_pix;
                    pix_next      = pix_reg + 1'b1;
                    d_next        = d_inc;
                    state_next    = last_pix ? S_IDLE : S_SETUP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= S_IDLE;
            strip_length_reg     <= STRIP_LENGTH_RESET;
            brightness_shift_reg <= '0;
            offset_reg           <= '0;
            m_tvalid_reg         <= 1'b0;
        end else begin
            state_reg            <= state_next;
            strip_length_reg     <= strip_length_next;
            brightness_shift_reg <= brightness_shift_next;
            offset_reg           <= offset_next;
            m_tvalid_reg         <= m_tvalid_next;
        end
        n_reg       <= n_next;
        len_reg     <= len_next;
        bsh_reg     <= bsh_next;
        mod_reg     <= mod_next;
        pix_reg     <= pix_next;
        d_reg       <= d_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // pixel position, distance and offset stay inside the ring during a frame
    a_pix_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SETUP) |-> ({1'b0, pix_reg} < n_reg))
        else $error("pixel index beyond strip length");

    a_dist_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SETUP) |-> ({1'b0, d_reg} < n_reg && {1'b0, offset_reg} < n_reg))
        else $error("distance or offset beyond strip length");

    // three sections always cover the ring
    a_sections_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SETUP) |-> ({2'b00, len_reg} * 3 >= 9'(n_reg)))
        else $error("sections do not cover the ring");

    // the last pixel ends the frame and frees the input side
    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_pix) |=> (state_reg == S_IDLE && m_tvalid_reg && m_tlast_reg))
        else $error("frame did not end on last pixel");

    // the pixel index advances by one with each pixel emitted before the last
    a_dist_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !last_pix) |=> (pix_reg == $past(pix_reg) + 1'b1))
        else $error("pixel index did not advance");

endmodule
